>>> src/dmc_pkg.sv
// Shared types and constants for the direct-mapped read cache.
// Used by the front, queue, back and top-level modules; depends on nothing.
package dmc_pkg;

    localparam int LINES      = 8;
    localparam int LINE_BYTES = 32;
    localparam int ADDR_W     = 32;
    localparam int LINE_W     = 27;
    localparam int CNT_W      = 32;
    localparam int DATA_W     = 32;

    localparam int OFF_W     = $clog2(LINE_BYTES);
    localparam int IDX_W     = $clog2(LINES);
    localparam int TAG_W     = ADDR_W - OFF_W - IDX_W;
    localparam int BEATS     = LINE_BYTES / 4;
    localparam int BEAT_W    = $clog2(BEATS);
    localparam int WADDR_W   = IDX_W + BEAT_W;
    localparam int BADDR_W   = IDX_W + OFF_W;
    localparam int MEM_DEPTH = LINES * BEATS;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_HIT    = 2'd0,
        ST_MISS   = 2'd1,
        ST_FILLED = 2'd2,
        ST_REJECT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_LAST,
        OP_HIT,
        OP_MISS,
        OP_REJECT
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [WADDR_W-1:0]  waddr;
        logic [BADDR_W-1:0]  raddr;
        logic [DATA_W-1:0]   word;
        logic [LINE_W-1:0]   line;
        logic [CNT_W-1:0]    hits;
        logic [CNT_W-1:0]    misses;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> src/dmc_front.sv
// Front end of the cache: accepts commands, checks tags, keeps the fill
// sequencing state and the counters, and pushes one queue entry per command.
// Depends on dmc_pkg.
module dmc_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_command,
    input  logic [dmc_pkg::ADDR_W-1:0]   i_address,
    input  logic [dmc_pkg::DATA_W-1:0]   i_fill_word,
    input  dmc_pkg::t_q_status           i_q_status,
    output logic                         o_push,
    output dmc_pkg::t_entry              o_entry
);

    logic [dmc_pkg::LINES-1:0]        r_valid;
    logic [dmc_pkg::TAG_W-1:0]        r_tag [dmc_pkg::LINES];
    logic                             r_pending;
    logic [dmc_pkg::ADDR_W-1:0]       r_paddr;
    logic [dmc_pkg::BEAT_W-1:0]       r_beat;
    logic [dmc_pkg::CNT_W-1:0]        r_hits;
    logic [dmc_pkg::CNT_W-1:0]        r_misses;

    logic [dmc_pkg::LINES-1:0]        n_valid;
    logic                             n_pending;
    logic [dmc_pkg::ADDR_W-1:0]       n_paddr;
    logic [dmc_pkg::BEAT_W-1:0]       n_beat;
    logic [dmc_pkg::CNT_W-1:0]        n_hits;
    logic [dmc_pkg::CNT_W-1:0]        n_misses;

    logic                             accept;
    logic [dmc_pkg::OFF_W-1:0]        a_off;
    logic [dmc_pkg::IDX_W-1:0]        a_idx;
    logic [dmc_pkg::TAG_W-1:0]        a_tag;
    logic [dmc_pkg::OFF_W-1:0]        p_off;
    logic [dmc_pkg::IDX_W-1:0]        p_idx;
    logic [dmc_pkg::TAG_W-1:0]        p_tag;
    logic                             hit;
    logic                             last_beat;
    logic                             tag_we;
    dmc_pkg::t_entry                  entry;

    assign accept    = i_valid && !i_q_status.full;
    assign a_off     = i_address[dmc_pkg::OFF_W-1:0];
    assign a_idx     = i_address[dmc_pkg::OFF_W +: dmc_pkg::IDX_W];
    assign a_tag     = i_address[dmc_pkg::ADDR_W-1 -: dmc_pkg::TAG_W];
    assign p_off     = r_paddr[dmc_pkg::OFF_W-1:0];
    assign p_idx     = r_paddr[dmc_pkg::OFF_W +: dmc_pkg::IDX_W];
    assign p_tag     = r_paddr[dmc_pkg::ADDR_W-1 -: dmc_pkg::TAG_W];
    assign hit       = r_valid[a_idx] && (r_tag[a_idx] == a_tag);
    assign last_beat = (r_beat == dmc_pkg::BEAT_W'(dmc_pkg::BEATS - 1));

    always_comb begin
        n_valid   = r_valid;
        n_pending = r_pending;
        n_paddr   = r_paddr;
        n_beat    = r_beat;
        n_hits    = r_hits;
        n_misses  = r_misses;
        tag_we    = 1'b0;

        entry.op     = dmc_pkg::OP_REJECT;
        entry.waddr  = {p_idx, r_beat};
        entry.raddr  = {p_idx, p_off};
        entry.word   = i_fill_word;
        entry.line   = '0;

        if (i_command == 1'b0) begin
            if (r_pending) begin
                entry.op = dmc_pkg::OP_REJECT;
            end else if (hit) begin
                entry.op    = dmc_pkg::OP_HIT;
                entry.raddr = {a_idx, a_off};
                entry.line  = dmc_pkg::LINE_W'(i_address >> dmc_pkg::OFF_W);
                n_hits      = r_hits + 1'b1;
            end else begin
                entry.op    = dmc_pkg::OP_MISS;
                entry.line  = dmc_pkg::LINE_W'(i_address >> dmc_pkg::OFF_W);
                n_misses    = r_misses + 1'b1;
                n_pending   = 1'b1;
                n_paddr     = i_address;
                n_beat      = '0;
            end
        end else begin
            if (!r_pending) begin
                entry.op = dmc_pkg::OP_REJECT;
            end else if (last_beat) begin
                entry.op   = dmc_pkg::OP_LAST;
                entry.line = dmc_pkg::LINE_W'(r_paddr >> dmc_pkg::OFF_W);
                n_valid[p_idx] = 1'b1;
                tag_we     = 1'b1;
                n_pending  = 1'b0;
                n_beat     = '0;
            end else begin
                entry.op = dmc_pkg::OP_WRITE;
                n_beat   = r_beat + 1'b1;
            end
        end

        // Counters travel with the entry as they stand after this command.
        entry.hits   = n_hits;
        entry.misses = n_misses;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_pending <= 1'b0;
            r_paddr   <= '0;
            r_beat    <= '0;
            r_hits    <= '0;
            r_misses  <= '0;
        end else if (accept) begin
            r_valid   <= n_valid;
            r_pending <= n_pending;
            r_paddr   <= n_paddr;
            r_beat    <= n_beat;
            r_hits    <= n_hits;
            r_misses  <= n_misses;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && tag_we) begin
            r_tag[p_idx] <= p_tag;
        end
    end

    assign o_push  = accept;
    assign o_entry = entry;

endmodule

>>> src/dmc_fifo.sv
// Short queue of decoded operations between the front and back ends.
// Depends on dmc_pkg.
module dmc_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dmc_pkg::t_entry     i_entry,
    input  logic                i_pop,
    output dmc_pkg::t_entry     o_head,
    output dmc_pkg::t_q_status  o_status
);

    dmc_pkg::t_entry             r_mem [dmc_pkg::Q_DEPTH];
    logic [dmc_pkg::Q_PTR_W-1:0] r_wp;
    logic [dmc_pkg::Q_PTR_W-1:0] r_rp;
    logic [dmc_pkg::Q_CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    assign o_head         = r_mem[r_rp];
    assign o_status.full  = (r_cnt == dmc_pkg::Q_CNT_W'(dmc_pkg::Q_DEPTH));
    assign o_status.empty = (r_cnt == '0);

endmodule

>>> src/dmc_back.sv
// Back end of the cache: holds the line data memory, applies fill words,
// reads the requested byte and drives the registered result.
// Depends on dmc_pkg.
module dmc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dmc_pkg::t_entry               i_head,
    input  dmc_pkg::t_q_status            i_q_status,
    output logic                          o_pop,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [1:0]                    o_status,
    output logic [7:0]                    o_data_byte,
    output logic [dmc_pkg::LINE_W-1:0]    o_line_address,
    output logic [dmc_pkg::CNT_W-1:0]     o_hits_so_far,
    output logic [dmc_pkg::CNT_W-1:0]     o_misses_so_far
);

    localparam int WSEL_W = dmc_pkg::BADDR_W - 2;

    logic [dmc_pkg::DATA_W-1:0]  r_mem [dmc_pkg::MEM_DEPTH];

    logic                        r_rd_pend;
    logic                        r_out_valid;
    logic [dmc_pkg::DATA_W-1:0]  r_rd_word;
    logic [dmc_pkg::DATA_W-1:0]  r_byp_word;
    logic                        r_byp;
    logic [1:0]                  r_lane;
    dmc_pkg::t_status            r_st;
    logic [dmc_pkg::LINE_W-1:0]  r_line;
    logic [dmc_pkg::CNT_W-1:0]   r_hits;
    logic [dmc_pkg::CNT_W-1:0]   r_misses;

    logic [1:0]                  r_o_status;
    logic [7:0]                  r_o_byte;
    logic [dmc_pkg::LINE_W-1:0]  r_o_line;
    logic [dmc_pkg::CNT_W-1:0]   r_o_hits;
    logic [dmc_pkg::CNT_W-1:0]   r_o_misses;

    logic                        out_free;
    logic                        pop;
    logic                        mem_we;
    logic [WSEL_W-1:0]           rd_sel;
    dmc_pkg::t_status            head_st;
    logic [dmc_pkg::DATA_W-1:0]  src_word;
    logic [7:0]                  n_byte;

    assign out_free = !r_out_valid || !i_out_stall;
    // Plain fill words need no output slot; everything else waits for one.
    assign pop = !i_q_status.empty && !r_rd_pend
                 && ((i_head.op == dmc_pkg::OP_WRITE) || out_free);
    assign mem_we = pop && ((i_head.op == dmc_pkg::OP_WRITE)
                            || (i_head.op == dmc_pkg::OP_LAST));
    assign rd_sel = i_head.raddr[dmc_pkg::BADDR_W-1:2];

    always_comb begin
        case (i_head.op)
            dmc_pkg::OP_HIT:  head_st = dmc_pkg::ST_HIT;
            dmc_pkg::OP_MISS: head_st = dmc_pkg::ST_MISS;
            dmc_pkg::OP_LAST: head_st = dmc_pkg::ST_FILLED;
            default:          head_st = dmc_pkg::ST_REJECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_head.waddr] <= i_head.word;
        end
        if (pop) begin
            r_rd_word  <= r_mem[rd_sel];
            r_byp_word <= i_head.word;
            // The last fill word is written in the same cycle it may be read.
            r_byp      <= (i_head.op == dmc_pkg::OP_LAST) && (rd_sel == i_head.waddr);
            r_lane     <= i_head.raddr[1:0];
            r_st       <= head_st;
            r_line     <= i_head.line;
            r_hits     <= i_head.hits;
            r_misses   <= i_head.misses;
        end
    end

    always_comb begin
        src_word = r_byp ? r_byp_word : r_rd_word;
        if ((r_st == dmc_pkg::ST_HIT) || (r_st == dmc_pkg::ST_FILLED)) begin
            n_byte = src_word[8*r_lane +: 8];
        end else begin
            n_byte = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= pop && (i_head.op != dmc_pkg::OP_WRITE);
            if (r_rd_pend) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            r_o_status <= r_st;
            r_o_byte   <= n_byte;
            r_o_line   <= r_line;
            r_o_hits   <= r_hits;
            r_o_misses <= r_misses;
        end
    end

    assign o_pop           = pop;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_data_byte     = r_o_byte;
    assign o_line_address  = r_o_line;
    assign o_hits_so_far   = r_o_hits;
    assign o_misses_so_far = r_o_misses;

endmodule

>>> src/direct_mapped_cache_read_core.sv
// Direct-mapped read cache, 8 lines of 32 bytes, with fill-word interface.
// A command passes through the queue, the read register and the output
// register. Fill words that end no line are taken one per cycle unless the
// queue is full or a read is pending; the back end takes no new entry while
// a read is pending. Synchronous active-low reset clears valid bits,
// counters, fill state and the queue; line data and tags are not cleared.
module direct_mapped_cache_read_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_command,
    input  logic [dmc_pkg::ADDR_W-1:0]    i_address,
    input  logic [dmc_pkg::DATA_W-1:0]    i_fill_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [7:0]                    o_data_byte,
    output logic [dmc_pkg::LINE_W-1:0]    o_line_address,
    output logic [dmc_pkg::CNT_W-1:0]     o_hits_so_far,
    output logic [dmc_pkg::CNT_W-1:0]     o_misses_so_far
);

    dmc_pkg::t_q_status q_status;
    dmc_pkg::t_entry    push_entry;
    dmc_pkg::t_entry    head_entry;
    logic               push;
    logic               pop;

    dmc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_command   (i_command),
        .i_address   (i_address),
        .i_fill_word (i_fill_word),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    dmc_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head_entry),
        .o_status (q_status)
    );

    dmc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head_entry),
        .i_q_status      (q_status),
        .o_pop           (pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_data_byte     (o_data_byte),
        .o_line_address  (o_line_address),
        .o_hits_so_far   (o_hits_so_far),
        .o_misses_so_far (o_misses_so_far)
    );

    assign o_in_stall = q_status.full;

endmodule

>>> src/dmc_checker.sv
// Port-level checks for the direct-mapped read cache, bound to the top level.
// Depends on dmc_pkg.
module dmc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [1:0]                    o_status,
    input logic [7:0]                    o_data_byte,
    input logic [dmc_pkg::LINE_W-1:0]    o_line_address,
    input logic [dmc_pkg::CNT_W-1:0]     o_hits_so_far,
    input logic [dmc_pkg::CNT_W-1:0]     o_misses_so_far
);

    // Reset empties both the queue and the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("output or stall still asserted after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status)
            && $stable(o_data_byte) && $stable(o_line_address)
            && $stable(o_hits_so_far) && $stable(o_misses_so_far)))
        else $error("stalled result changed");

    a_no_byte_without_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_status == dmc_pkg::ST_MISS)
                         || (o_status == dmc_pkg::ST_REJECT))) |-> (o_data_byte == 8'd0))
        else $error("data byte set on a result that carries none");

    a_reject_no_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == dmc_pkg::ST_REJECT)) |-> (o_line_address == '0))
        else $error("rejected command reports a line address");

endmodule

bind direct_mapped_cache_read_core dmc_checker u_dmc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_data_byte     (o_data_byte),
    .o_line_address  (o_line_address),
    .o_hits_so_far   (o_hits_so_far),
    .o_misses_so_far (o_misses_so_far)
);
